[design/dts_pkg.sv]
// Package for the table-driven automaton step block.
// Holds shared codes, register reset values and the control/status structs.
// No dependencies.
package dts_pkg;

   // Default sizes of the stores.
   localparam int DEF_MAX_STATES  = 256;
   localparam int DEF_MAX_CLASSES = 64;

   // Field widths fixed by the interface.
   localparam int SYM_W      = 21;
   localparam int NCLS_REG_W = 7;
   localparam int NST_REG_W  = 9;
   localparam int DEST_W     = 9;

   // Operation codes.
   localparam logic [1:0] OP_LOAD_START  = 2'd0;
   localparam logic [1:0] OP_LOAD_TRANS  = 2'd1;
   localparam logic [1:0] OP_LOAD_ACCEPT = 2'd2;
   localparam logic [1:0] OP_STEP        = 2'd3;

   // Error codes.
   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_SYMBOL = 2'd1;
   localparam logic [1:0] ERR_STATE  = 2'd2;

   // Register indexes.
   localparam logic [1:0] CSR_ALPHABET_SIZE = 2'd0;
   localparam logic [1:0] CSR_NUM_CLASSES   = 2'd1;
   localparam logic [1:0] CSR_NUM_STATES    = 2'd2;

   // Register reset values.
   localparam logic [SYM_W-1:0]      ALPHABET_RESET    = 21'd256;
   localparam logic [NCLS_REG_W-1:0] NUM_CLASSES_RESET = 7'd1;
   localparam logic [NST_REG_W-1:0]  NUM_STATES_RESET  = 9'd1;

   // Destination value that marks a dead step.
   localparam logic signed [DEST_W-1:0] DEAD_STATE = -9'sd1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;    // request accepted this cycle
      logic search;  // one binary search iteration
      logic lookup;  // transition entry is on the read port
      logic emit;    // drive the response registers
   } dts_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_step;      // the offered request is a step
      logic fault;        // the offered step has a symbol or state error
      logic search_done;  // the class is settled after this cycle
   } dts_sts_type;

endpackage

[design/dts_ctrl.sv]
// Controller state machine of the automaton step block.
// Depends on dts_pkg for the command and status structs.
module dts_ctrl import dts_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  dts_sts_type sts,
   output logic        busy,
   output dts_cmd_type cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SEARCH = 5'b00010,
      ST_TRANS  = 5'b00100,
      ST_ACC    = 5'b01000,
      ST_FAULT  = 5'b10000
   } dts_state_type;

   dts_state_type state_ff;
   dts_state_type state_in;

   // Next state: a step searches for its class, reads the transition and
   // then the accept flag; a faulty step reports at once; loads leave the state idle.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start && sts.is_step) begin
               state_in = sts.fault ? ST_FAULT : ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (sts.search_done) begin
               state_in = ST_TRANS;
            end
         end
         ST_TRANS: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            state_in = ST_IDLE;
         end
         ST_FAULT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Commands decoded from the state.
   assign busy       = (state_ff != ST_IDLE);
   assign cmd.take   = (state_ff == ST_IDLE) && start;
   assign cmd.search = (state_ff == ST_SEARCH);
   assign cmd.lookup = (state_ff == ST_TRANS);
   assign cmd.emit   = (state_ff == ST_ACC) || (state_ff == ST_FAULT);

endmodule

[design/dts_datapath.sv]
// Datapath of the automaton step block: registers, the three stores,
// the binary class search and the response registers. Depends on dts_pkg.
module dts_datapath import dts_pkg::*; #(
   parameter int MAX_STATES  = DEF_MAX_STATES,
   parameter int MAX_CLASSES = DEF_MAX_CLASSES
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dts_cmd_type              cmd,
   output dts_sts_type              sts,
   input  logic [1:0]               req_operation,
   input  logic [7:0]               req_state_index,
   input  logic [5:0]               req_class_index,
   input  logic [SYM_W-1:0]         req_symbol,
   input  logic signed [DEST_W-1:0] req_dest_state,
   input  logic                     req_accept_flag,
   input  logic                     csr_write_enable,
   input  logic [1:0]               csr_index,
   input  logic [SYM_W-1:0]         csr_write_data,
   output logic                     rsp_valid,
   output logic signed [DEST_W-1:0] rsp_next_state,
   output logic                     rsp_next_accepting,
   output logic                     rsp_current_accepting,
   output logic [1:0]               rsp_error_code
);

   localparam int ST_W     = $clog2(MAX_STATES);
   localparam int CLS_W    = $clog2(MAX_CLASSES);
   localparam int CNT_W    = $clog2(MAX_CLASSES + 1);
   localparam int SCNT_W   = $clog2(MAX_STATES + 1);
   localparam int NC_W     = (CNT_W > NCLS_REG_W) ? CNT_W : NCLS_REG_W;
   localparam int NS_W     = (SCNT_W > NST_REG_W) ? SCNT_W : NST_REG_W;
   localparam int TR_DEPTH = MAX_STATES * (2 ** CLS_W);

   // Configuration registers.
   logic [SYM_W-1:0]      alphabet_size_ff;
   logic [NCLS_REG_W-1:0] num_classes_ff;
   logic [NST_REG_W-1:0]  num_states_ff;

   logic [CNT_W-1:0]  eff_classes;
   logic [SCNT_W-1:0] eff_states;

   // Request registers and search state.
   logic [7:0]        st_ff;
   logic [SYM_W-1:0]  sym_ff;
   logic [1:0]        err_ff;
   logic              st_ok_ff;
   logic [CNT_W-1:0]  lo_ff;
   logic [CNT_W-1:0]  hi_ff;
   logic [CNT_W-1:0]  lo_in;
   logic [CNT_W-1:0]  hi_in;
   logic [CNT_W:0]    mid_sum;
   logic [CNT_W-1:0]  mid;
   logic [CNT_W:0]    nmid_sum;
   logic [CNT_W-1:0]  nmid;
   logic              search_live;
   logic              done_next;

   // Lookup results.
   logic              live_ff;
   logic [7:0]        next_ff;
   logic              cur_acc_ff;
   logic              dest_ok;

   // Stores and their registered read data.
   logic [SYM_W-1:0]  cls_mem [MAX_CLASSES];
   logic [SYM_W-1:0]  cls_rd;
   logic [DEST_W-1:0] tr_mem [TR_DEPTH];
   logic [DEST_W-1:0] tr_rd;
   logic              acc_mem [MAX_STATES];
   logic              acc_rd;

   // Request decode.
   logic sym_err;
   logic st_ok;
   logic st_in_range;
   logic cls_in_range;
   logic ld_start;
   logic ld_trans;
   logic ld_accept;

   // Response registers.
   logic                     rsp_valid_ff;
   logic signed [DEST_W-1:0] rsp_next_state_ff;
   logic                     rsp_next_accepting_ff;
   logic                     rsp_current_accepting_ff;
   logic [1:0]               rsp_error_code_ff;

   // Configuration writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         alphabet_size_ff <= ALPHABET_RESET;
         num_classes_ff   <= NUM_CLASSES_RESET;
         num_states_ff    <= NUM_STATES_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ALPHABET_SIZE: alphabet_size_ff <= csr_write_data;
            CSR_NUM_CLASSES:   num_classes_ff   <= csr_write_data[NCLS_REG_W-1:0];
            CSR_NUM_STATES:    num_states_ff    <= csr_write_data[NST_REG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Counts in use, clamped into one up to the store size.
   always_comb begin
      if (num_classes_ff == '0) begin
         eff_classes = CNT_W'(1);
      end else if (NC_W'(num_classes_ff) > NC_W'(MAX_CLASSES)) begin
         eff_classes = CNT_W'(MAX_CLASSES);
      end else begin
         eff_classes = CNT_W'(num_classes_ff);
      end
      if (num_states_ff == '0) begin
         eff_states = SCNT_W'(1);
      end else if (NS_W'(num_states_ff) > NS_W'(MAX_STATES)) begin
         eff_states = SCNT_W'(MAX_STATES);
      end else begin
         eff_states = SCNT_W'(num_states_ff);
      end
   end

   // Request checks and load strobes.
   assign sym_err      = (req_symbol >= alphabet_size_ff);
   assign st_ok        = (NS_W'(req_state_index) < NS_W'(eff_states));
   assign st_in_range  = (32'(req_state_index) < 32'(MAX_STATES));
   assign cls_in_range = (32'(req_class_index) < 32'(MAX_CLASSES));
   assign ld_start     = cmd.take && (req_operation == OP_LOAD_START) && cls_in_range;
   assign ld_trans     = cmd.take && (req_operation == OP_LOAD_TRANS)
                         && st_in_range && cls_in_range;
   assign ld_accept    = cmd.take && (req_operation == OP_LOAD_ACCEPT) && st_in_range;

   assign sts.is_step     = (req_operation == OP_STEP);
   assign sts.fault       = sym_err || !st_ok;
   assign sts.search_done = done_next;

   // One binary search iteration per cycle. The start point for the current
   // midpoint is on the read port; the next midpoint is addressed at once.
   always_comb begin
      mid_sum     = {1'b0, lo_ff} + {1'b0, hi_ff};
      mid         = mid_sum[CNT_W:1];
      search_live = ((hi_ff - lo_ff) > CNT_W'(1));
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      if (cmd.take) begin
         lo_in = '0;
         hi_in = eff_classes;
      end else if (cmd.search && search_live) begin
         if (cls_rd > sym_ff) begin
            hi_in = mid;
         end else if (cls_rd < sym_ff) begin
            lo_in = mid;
         end else begin
            // Exact hit on a start point ends the search.
            lo_in = mid;
            hi_in = mid + CNT_W'(1);
         end
      end
      done_next = ((hi_in - lo_in) <= CNT_W'(1));
      nmid_sum  = {1'b0, lo_in} + {1'b0, hi_in};
      nmid      = nmid_sum[CNT_W:1];
   end

   // Request registers.
   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      if (cmd.take) begin
         st_ff    <= req_state_index;
         sym_ff   <= req_symbol;
         st_ok_ff <= st_ok;
         live_ff  <= 1'b0;
         if (sym_err) begin
            err_ff <= ERR_SYMBOL;
         end else if (!st_ok) begin
            err_ff <= ERR_STATE;
         end else begin
            err_ff <= ERR_NONE;
         end
      end else if (cmd.lookup) begin
         live_ff    <= dest_ok;
         next_ff    <= tr_rd[7:0];
         cur_acc_ff <= acc_rd;
      end
   end

   // A stored destination counts only when it is non-negative and in use.
   assign dest_ok = !tr_rd[DEST_W-1] && (NS_W'(tr_rd[7:0]) < NS_W'(eff_states));

   // Class start point store.
   always_ff @(posedge clock) begin
      if (ld_start) begin
         cls_mem[CLS_W'(req_class_index)] <= req_symbol;
      end
      if (cmd.take || cmd.search) begin
         cls_rd <= cls_mem[CLS_W'(nmid)];
      end
   end

   // Transition store, addressed by state and class.
   always_ff @(posedge clock) begin
      if (ld_trans) begin
         tr_mem[{ST_W'(req_state_index), CLS_W'(req_class_index)}] <= req_dest_state;
      end
      if (cmd.search) begin
         tr_rd <= tr_mem[{ST_W'(st_ff), CLS_W'(lo_in)}];
      end
   end

   // Accept flag store: read for the current state at request time,
   // and for the destination once the transition is known.
   always_ff @(posedge clock) begin
      if (ld_accept) begin
         acc_mem[ST_W'(req_state_index)] <= req_accept_flag;
      end
      if (cmd.take) begin
         acc_rd <= acc_mem[ST_W'(req_state_index)];
      end else if (cmd.lookup) begin
         acc_rd <= acc_mem[ST_W'(tr_rd[7:0])];
      end
   end

   // Response registers. A faulty step reports the cycle after it is taken,
   // while the current state's flag is still on the read port.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_next_state_ff     <= live_ff ? $signed({1'b0, next_ff}) : DEAD_STATE;
         rsp_next_accepting_ff <= live_ff && acc_rd;
         rsp_error_code_ff     <= err_ff;
         if (err_ff != ERR_NONE) begin
            rsp_current_accepting_ff <= st_ok_ff && acc_rd;
         end else begin
            rsp_current_accepting_ff <= cur_acc_ff;
         end
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_next_state        = rsp_next_state_ff;
   assign rsp_next_accepting    = rsp_next_accepting_ff;
   assign rsp_current_accepting = rsp_current_accepting_ff;
   assign rsp_error_code        = rsp_error_code_ff;

endmodule

[design/dfa_table_step.sv]
// Top level of the table-driven automaton step block.
// Instantiates dts_ctrl and dts_datapath; depends on dts_pkg.
//
//   Channel   Ports                       Handshake
//   request   start, busy, req_*          taken when start is high and busy low
//   response  rsp_valid, rsp_*            one-cycle strobe, receiver cannot stall
//   config    csr_write_enable, csr_*     written on every edge with enable high
//
// Loads give no response; busy stays low.
// A step with a symbol or state error responds from the fault state, with no search.
// A good step runs S binary search iterations, S being about ceil(log2(num_classes))
// and at least one, then reads the transition entry and the accept flag.
// The search reads one class start point per cycle on the start point store.
// Reset is synchronous; the stores are not cleared and must be loaded first.
module dfa_table_step import dts_pkg::*; #(
   parameter int MAX_STATES  = DEF_MAX_STATES,
   parameter int MAX_CLASSES = DEF_MAX_CLASSES
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_operation,
   input  logic [7:0]               req_state_index,
   input  logic [5:0]               req_class_index,
   input  logic [SYM_W-1:0]         req_symbol,
   input  logic signed [DEST_W-1:0] req_dest_state,
   input  logic                     req_accept_flag,
   output logic                     rsp_valid,
   output logic signed [DEST_W-1:0] rsp_next_state,
   output logic                     rsp_next_accepting,
   output logic                     rsp_current_accepting,
   output logic [1:0]               rsp_error_code,
   input  logic                     csr_write_enable,
   input  logic [1:0]               csr_index,
   input  logic [SYM_W-1:0]         csr_write_data
);

   dts_cmd_type cmd;
   dts_sts_type sts;

   // Sequencing of each request.
   dts_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .busy  (busy),
      .cmd   (cmd)
   );

   // Stores, class search and response registers.
   dts_datapath #(
      .MAX_STATES  (MAX_STATES),
      .MAX_CLASSES (MAX_CLASSES)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .sts                   (sts),
      .req_operation         (req_operation),
      .req_state_index       (req_state_index),
      .req_class_index       (req_class_index),
      .req_symbol            (req_symbol),
      .req_dest_state        (req_dest_state),
      .req_accept_flag       (req_accept_flag),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data),
      .rsp_valid             (rsp_valid),
      .rsp_next_state        (rsp_next_state),
      .rsp_next_accepting    (rsp_next_accepting),
      .rsp_current_accepting (rsp_current_accepting),
      .rsp_error_code        (rsp_error_code)
   );

endmodule

[design/dts_checker.sv]
// Port-level checks of the automaton step block, bound to dfa_table_step.
// Depends on dts_pkg.
module dts_checker import dts_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic [1:0]               req_operation,
   input logic                     rsp_valid,
   input logic signed [DEST_W-1:0] rsp_next_state,
   input logic                     rsp_next_accepting,
   input logic [1:0]               rsp_error_code
);

   // A load finishes in the cycle it is taken.
   a_load_quick: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation != OP_STEP) |=> !busy)
      else $error("busy after a load request");

   // A step keeps the block busy.
   a_step_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation == OP_STEP) |=> busy)
      else $error("not busy after a step request");

   // A response only ends a busy period.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response without a step in progress");

   // One response per step.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response repeated");

   // An error response is always dead.
   a_err_dead: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error_code != ERR_NONE)
         |-> (rsp_next_state == DEAD_STATE && !rsp_next_accepting))
      else $error("error response with a live next state");

endmodule

bind dfa_table_step dts_checker u_dts_checker (.*);

[dv/dfa_table_step_tb.sv]
// Self-checking testbench for the table-driven automaton step block.
// Loads the tables, steps the automaton under many register settings and
// checks every response against its own model; depends on dts_pkg and dfa_table_step.
module dfa_table_step_tb;
   import dts_pkg::*;

   localparam int         CYCLE_LIMIT = 800000;
   localparam int         SETTLE      = 16;
   localparam logic [1:0] CSR_SPARE   = 2'd3;
   localparam logic [SYM_W-1:0] SYM_MAX = 21'h1FFFFF;

   typedef struct packed {
      logic signed [DEST_W-1:0] next_state;
      logic                     next_acc;
      logic                     cur_acc;
      logic [1:0]               err;
   } step_result_type;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [1:0]               req_operation = OP_LOAD_START;
   logic [7:0]               req_state_index = '0;
   logic [5:0]               req_class_index = '0;
   logic [SYM_W-1:0]         req_symbol = '0;
   logic signed [DEST_W-1:0] req_dest_state = '0;
   logic                     req_accept_flag = 1'b0;
   logic                     rsp_valid;
   logic signed [DEST_W-1:0] rsp_next_state;
   logic                     rsp_next_accepting;
   logic                     rsp_current_accepting;
   logic [1:0]               rsp_error_code;
   logic                     csr_write_enable = 1'b0;
   logic [1:0]               csr_index = CSR_ALPHABET_SIZE;
   logic [SYM_W-1:0]         csr_write_data = '0;

   // Model of the registers and stores.
   logic [SYM_W-1:0]      cfg_alphabet = ALPHABET_RESET;
   logic [NCLS_REG_W-1:0] cfg_classes  = NUM_CLASSES_RESET;
   logic [NST_REG_W-1:0]  cfg_states   = NUM_STATES_RESET;
   logic [SYM_W-1:0]      start_mem  [0:DEF_MAX_CLASSES-1];
   logic [DEST_W-1:0]     dest_mem   [0:DEF_MAX_STATES-1][0:DEF_MAX_CLASSES-1];
   bit                    dest_set   [0:DEF_MAX_STATES-1][0:DEF_MAX_CLASSES-1];
   logic                  accept_mem [0:DEF_MAX_STATES-1];

   step_result_type pending_steps[$];

   int  failures = 0;
   int  cycle_count = 0;
   int  requests_sent = 0;
   int  steps_sent = 0;
   int  symbol_faults = 0;
   int  state_faults = 0;
   int  dead_steps = 0;
   int  csr_writes = 0;
   bit  steady = 1'b0;

   dfa_table_step dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_operation         (req_operation),
      .req_state_index       (req_state_index),
      .req_class_index       (req_class_index),
      .req_symbol            (req_symbol),
      .req_dest_state        (req_dest_state),
      .req_accept_flag       (req_accept_flag),
      .rsp_valid             (rsp_valid),
      .rsp_next_state        (rsp_next_state),
      .rsp_next_accepting    (rsp_next_accepting),
      .rsp_current_accepting (rsp_current_accepting),
      .rsp_error_code        (rsp_error_code),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The register values saturate into the sizes of the stores.
   function automatic int unsigned class_limit();
      if (cfg_classes == 0) return 1;
      if (cfg_classes > DEF_MAX_CLASSES) return DEF_MAX_CLASSES;
      return cfg_classes;
   endfunction

   function automatic int unsigned state_limit();
      if (cfg_states == 0) return 1;
      if (cfg_states > DEF_MAX_STATES) return DEF_MAX_STATES;
      return cfg_states;
   endfunction

   // Binary search for the largest class whose start point is at most sym.
   function automatic int unsigned locate_class(logic [SYM_W-1:0] sym);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      lo = 0;
      hi = class_limit();
      while (hi - lo > 1) begin
         mid = (lo + hi) >> 1;
         if (start_mem[mid] > sym) hi = mid;
         else if (start_mem[mid] < sym) lo = mid;
         else return mid;
      end
      return lo;
   endfunction

   // Expected response of one step request.
   function automatic step_result_type predict_step(logic [7:0] st, logic [SYM_W-1:0] sym);
      step_result_type r;
      logic         st_ok;
      logic [DEST_W-1:0] d;
      r.next_state = DEAD_STATE;
      r.next_acc   = 1'b0;
      r.cur_acc    = 1'b0;
      r.err        = ERR_NONE;
      st_ok = (st < state_limit());
      if (st_ok) r.cur_acc = accept_mem[st];
      if (sym >= cfg_alphabet) begin
         r.err = ERR_SYMBOL;
      end else if (!st_ok) begin
         r.err = ERR_STATE;
      end else begin
         d = dest_mem[st][locate_class(sym)];
         if (!d[DEST_W-1] && d < state_limit()) begin
            r.next_state = d;
            r.next_acc   = accept_mem[d];
         end
      end
      return r;
   endfunction

   // Destination for a transition load under the current settings.
   function automatic logic signed [DEST_W-1:0] pick_dest();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 75) return $urandom_range(state_limit() - 1);
      if (r < 85) return DEAD_STATE;
      if (r < 95) return $urandom;
      return (state_limit() < DEF_MAX_STATES) ? state_limit() : DEF_MAX_STATES - 1;
   endfunction

   // Sends one request and updates the model at the edge that accepts it.
   task automatic issue_request(logic [1:0] op, logic [7:0] st, logic [5:0] cl,
                                logic [SYM_W-1:0] sym, logic signed [DEST_W-1:0] dest,
                                logic acc);
      step_result_type r;
      while (!steady && $urandom_range(99) < 32) begin
         start <= 1'b0;
         req_operation <= $urandom;
         req_symbol <= $urandom;
         @(posedge clock);
      end
      req_operation   <= op;
      req_state_index <= st;
      req_class_index <= cl;
      req_symbol      <= sym;
      req_dest_state  <= dest;
      req_accept_flag <= acc;
      start           <= 1'b1;
      do @(posedge clock); while (busy);
      requests_sent++;
      case (op)
         OP_LOAD_START:  start_mem[cl] = sym;
         OP_LOAD_TRANS: begin
            dest_mem[st][cl] = dest;
            dest_set[st][cl] = 1'b1;
         end
         OP_LOAD_ACCEPT: accept_mem[st] = acc;
         default: begin
            r = predict_step(st, sym);
            pending_steps.push_back(r);
            steps_sent++;
            if (r.err == ERR_SYMBOL) symbol_faults++;
            else if (r.err == ERR_STATE) state_faults++;
            else if (r.next_state == DEAD_STATE) dead_steps++;
         end
      endcase
   endtask

   task automatic load_start(logic [5:0] cl, logic [SYM_W-1:0] sym);
      issue_request(OP_LOAD_START, $urandom, cl, sym, $urandom, $urandom);
   endtask

   task automatic load_dest(logic [7:0] st, logic [5:0] cl, logic signed [DEST_W-1:0] dest);
      issue_request(OP_LOAD_TRANS, st, cl, $urandom, dest, $urandom);
   endtask

   task automatic load_accept(logic [7:0] st, logic acc);
      issue_request(OP_LOAD_ACCEPT, st, $urandom, $urandom, $urandom, acc);
   endtask

   // A step that will read a transition entry not yet loaded loads it first.
   task automatic do_step(logic [7:0] st, logic [SYM_W-1:0] sym);
      int unsigned c;
      if (sym < cfg_alphabet && st < state_limit()) begin
         c = locate_class(sym);
         if (!dest_set[st][c]) load_dest(st, 6'(c), pick_dest());
      end
      issue_request(OP_STEP, st, $urandom, sym, $urandom, $urandom);
   endtask

   // Waits until every step has responded and the block has gone quiet.
   task automatic drain();
      start <= 1'b0;
      while (pending_steps.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_register(logic [1:0] idx, logic [SYM_W-1:0] val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      csr_writes++;
      case (idx)
         CSR_ALPHABET_SIZE: cfg_alphabet = val;
         CSR_NUM_CLASSES:   cfg_classes = val[NCLS_REG_W-1:0];
         CSR_NUM_STATES:    cfg_states = val[NST_REG_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic configure(logic [SYM_W-1:0] alpha, logic [SYM_W-1:0] ncls,
                            logic [SYM_W-1:0] nst);
      drain();
      write_register(CSR_ALPHABET_SIZE, alpha);
      write_register(CSR_NUM_CLASSES, ncls);
      write_register(CSR_NUM_STATES, nst);
   endtask

   // Loads the first count start points in ascending order, with occasional
   // duplicates.
   task automatic reload_starts(int unsigned gap, int unsigned count);
      int unsigned pt;
      pt = ($urandom_range(3) == 0) ? $urandom_range(gap) : 0;
      for (int i = 0; i < count; i++) begin
         load_start(6'(i), SYM_W'(pt));
         pt += $urandom_range(2 * gap);
         if (pt > SYM_MAX) pt = SYM_MAX;
      end
   endtask

   // Steps mostly near class boundaries and mostly from states in use.
   task automatic random_step();
      logic [7:0]       st;
      logic [SYM_W-1:0] sym;
      int unsigned      r;
      st = ($urandom_range(9) != 0) ? $urandom_range(state_limit() - 1) : $urandom_range(255);
      r = $urandom_range(99);
      if (r < 60) begin
         sym = start_mem[$urandom_range(class_limit() - 1)] + $urandom_range(2) - 1;
      end else if (r < 85 && cfg_alphabet != 0) begin
         sym = $urandom_range(cfg_alphabet - 1);
      end else begin
         sym = $urandom;
      end
      do_step(st, sym);
   endtask

   task automatic random_request();
      int unsigned r;
      logic [5:0]  cl;
      r = $urandom_range(99);
      cl = $urandom;
      if (r < 6) begin
         load_start(cl, $urandom_range(1) ? start_mem[cl] + $urandom_range(3) : $urandom);
      end else if (r < 18) begin
         load_dest(($urandom_range(9) != 0) ? $urandom_range(state_limit() - 1) : $urandom,
                   cl, pick_dest());
      end else if (r < 26) begin
         load_accept($urandom, $urandom);
      end else begin
         random_step();
      end
   endtask

   // All start points and accept flags are written up front; transition
   // entries are written as the steps come to need them.
   task automatic test_table_load();
      steady = 1'b1;
      reload_starts(SYM_MAX / DEF_MAX_CLASSES, DEF_MAX_CLASSES);
      for (int s = 0; s < DEF_MAX_STATES; s++) begin
         load_accept(8'(s), 1'($urandom));
      end
      steady = 1'b0;
   endtask

   // Field extremes, error precedence and dead or stray destinations.
   task automatic test_step_edges();
      logic [SYM_W-1:0] sym;
      int unsigned      c;
      // Reset settings: one class, one state, alphabet of 256.
      do_step(0, 0);
      do_step(0, 255);
      do_step(0, 256);
      do_step(1, 10);
      do_step(200, 300);
      configure(SYM_MAX, 64, 256);
      do_step(255, SYM_MAX - 1);
      do_step(0, 0);
      do_step(0, SYM_MAX);
      // Step into an accepting state, then into a dead and a maximal destination.
      sym = start_mem[37] + 1;
      c = locate_class(sym);
      load_accept(7, 1'b1);
      load_dest(7, c, 7);
      do_step(7, sym);
      load_accept(9, 1'b0);
      load_dest(9, c, DEAD_STATE);
      do_step(9, sym);
      load_dest(9, c, 255);
      do_step(9, sym);
      // With fewer states the same destination becomes a stray one.
      configure(SYM_MAX, 64, 16);
      do_step(9, sym);
      do_step(16, sym);
      do_step(15, sym);
      // Unsorted start points: the search result stands as it falls.
      load_start(1, SYM_MAX);
      do_step(3, start_mem[2]);
      load_start(32, 0);
      do_step(3, start_mem[40]);
   endtask

   // Saturation of the registers, alphabet of zero and the unused index.
   task automatic test_register_limits();
      configure(0, 64, 256);
      repeat (3) random_step();
      configure(SYM_MAX, 0, 0);
      repeat (3) random_step();
      configure(SYM_MAX, 127, 511);
      repeat (3) random_step();
      configure(SYM_MAX, 21'h1FFF00 | 21'd65, 21'h1FFE00 | 21'd257);
      repeat (3) random_step();
      configure(21'd1114112, 64, 256);
      write_register(CSR_SPARE, $urandom);
      do_step(3, 21'd1114111);
      do_step(3, 21'd1114112);
   endtask

   task automatic test_random_traffic(logic [SYM_W-1:0] alpha, int unsigned ncls,
                                      int unsigned nst, int count, bit quiet);
      int unsigned span;
      configure(alpha, ncls, nst);
      span = (alpha == 0) ? SYM_MAX : alpha;
      reload_starts(span / class_limit(), class_limit());
      steady = quiet;
      repeat (count) random_request();
      steady = 1'b0;
   endtask

   // Response checker: one strobe, one expectation, compared field by field.
   always @(posedge clock) begin
      step_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_steps.size() == 0) begin
            $error("response with no step pending");
            failures++;
         end else begin
            want = pending_steps.pop_front();
            if (rsp_next_state !== want.next_state) begin
               $error("next_state: expected %0d, got %0d",
                      $signed(want.next_state), rsp_next_state);
               failures++;
            end
            if (rsp_next_accepting !== want.next_acc) begin
               $error("next_accepting: expected %0d, got %0d",
                      want.next_acc, rsp_next_accepting);
               failures++;
            end
            if (rsp_current_accepting !== want.cur_acc) begin
               $error("current_accepting: expected %0d, got %0d",
                      want.cur_acc, rsp_current_accepting);
               failures++;
            end
            if (rsp_error_code !== want.err) begin
               $error("error_code: expected %0d, got %0d", want.err, rsp_error_code);
               failures++;
            end
         end
      end
   end

   // Watchdog against a hung block.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_table_load();
      test_step_edges();
      test_register_limits();
      test_random_traffic(21'd1114112, 64, 256, 150, 1'b0);
      test_random_traffic(21'd256, 1, 1, 150, 1'b0);
      test_random_traffic($urandom_range(1, SYM_MAX), $urandom_range(1, 64),
                          $urandom_range(1, 256), 150, 1'b0);
      test_random_traffic(SYM_MAX, 2, 2, 150, 1'b1);
      test_random_traffic($urandom_range(1, SYM_MAX), 33, 100, 150, 1'b0);
      drain();
      $display("Sent %0d requests and %0d register writes; %0d steps were checked.",
               requests_sent, csr_writes, steps_sent);
      $display("Steps with symbol faults: %0d, state faults: %0d, dead endings: %0d.",
               symbol_faults, state_faults, dead_steps);
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
